### hw/rtl/u8sd_pkg.sv
// Shared types and constants for the streaming UTF-8 decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int unsigned CpW = 21;

	// Input transaction: one raw byte and the end-of-buffer flag
	typedef struct packed {
		logic [7:0] byte_in;
		logic       final_byte;
	} item_t;

	// Output transaction: one decoded or rejected result
	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           is_invalid;
		logic           run_last;
	} result_t;

	// What closes a job after its invalid burst
	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_CODE = 2'd1,
		TAIL_BAD  = 2'd2
	} tail_kind_t;

	// Work handed from the front end to the back end, one per byte with results
	typedef struct packed {
		logic [1:0]     n_bad;
		tail_kind_t     tail_kind;
		logic [CpW-1:0] code;
	} job_t;

	localparam logic [2:0] LenNone = 3'd0;
	localparam logic [2:0] LenTwo  = 3'd2;
	localparam logic [2:0] LenThree = 3'd3;
	localparam logic [2:0] LenFour = 3'd4;

endpackage

### hw/rtl/u8sd_front.sv
// Front end: classifies each byte, keeps the partial sequence, builds jobs.
`timescale 1ns / 1ps

module u8sd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  u8sd_pkg::item_t item,
	input  logic            accept,
	output logic            job_push,
	output u8sd_pkg::job_t  job
);

	logic [u8sd_pkg::CpW-1:0] partial_q;
	logic [2:0]               exp_len_q;
	logic [1:0]               have_q;

	logic [u8sd_pkg::CpW-1:0] partial_d;
	logic [2:0]               exp_len_d;
	logic [1:0]               have_d;

	logic                     is_cont;
	logic                     completes;
	logic                     do_lead;
	logic [2:0]               lead_len;
	logic [u8sd_pkg::CpW-1:0] shifted;

	// Classify the byte and the pending sequence
	always_comb begin
		is_cont   = (item.byte_in[7:6] == 2'b10);
		completes = is_cont && (({1'b0, have_q} + 3'd2) == exp_len_q);
		shifted   = {partial_q[u8sd_pkg::CpW-7:0], item.byte_in[5:0]};
		if (item.byte_in[7:5] == 3'b110) begin
			lead_len = u8sd_pkg::LenTwo;
		end else if (item.byte_in[7:4] == 4'b1110) begin
			lead_len = u8sd_pkg::LenThree;
		end else if (item.byte_in[7:3] == 5'b11110) begin
			lead_len = u8sd_pkg::LenFour;
		end else begin
			lead_len = u8sd_pkg::LenNone;
		end
	end

	// Build the job and next sequence state
	always_comb begin
		partial_d     = partial_q;
		exp_len_d     = exp_len_q;
		have_d        = have_q;
		job.n_bad     = 2'd0;
		job.tail_kind = u8sd_pkg::TAIL_NONE;
		job.code      = '0;
		do_lead       = 1'b0;

		if (exp_len_q == u8sd_pkg::LenNone) begin
			do_lead = 1'b1;
		end else if (completes) begin
			job.tail_kind = u8sd_pkg::TAIL_CODE;
			job.code      = shifted;
			partial_d     = '0;
			exp_len_d     = u8sd_pkg::LenNone;
			have_d        = 2'd0;
		end else if (is_cont && !item.final_byte) begin
			partial_d = shifted;
			have_d    = have_q + 2'd1;
		end else begin
			// Drop the lead and buffered continuations, then retry as a lead
			job.n_bad = have_q + 2'd1;
			partial_d = '0;
			exp_len_d = u8sd_pkg::LenNone;
			have_d    = 2'd0;
			do_lead   = 1'b1;
		end

		if (do_lead) begin
			if (!item.byte_in[7]) begin
				job.tail_kind = u8sd_pkg::TAIL_CODE;
				job.code      = {{(u8sd_pkg::CpW-8){1'b0}}, item.byte_in};
			end else if (lead_len == u8sd_pkg::LenNone || item.final_byte) begin
				job.tail_kind = u8sd_pkg::TAIL_BAD;
			end else begin
				exp_len_d = lead_len;
				have_d    = 2'd0;
				case (lead_len)
					u8sd_pkg::LenTwo:   partial_d = {{(u8sd_pkg::CpW-5){1'b0}}, item.byte_in[4:0]};
					u8sd_pkg::LenThree: partial_d = {{(u8sd_pkg::CpW-4){1'b0}}, item.byte_in[3:0]};
					default:            partial_d = {{(u8sd_pkg::CpW-3){1'b0}}, item.byte_in[2:0]};
				endcase
			end
		end
	end

	assign job_push = accept &&
		((job.n_bad != 2'd0) || (job.tail_kind != u8sd_pkg::TAIL_NONE));

	// Advance the sequence state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			exp_len_q <= u8sd_pkg::LenNone;
			have_q    <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_d;
			exp_len_q <= exp_len_d;
			have_q    <= have_d;
		end
	end

endmodule

### hw/rtl/u8sd_job_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module u8sd_job_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8sd_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output u8sd_pkg::job_t rd_job
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	u8sd_pkg::job_t  slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = slots_q[rd_ptr_q];

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/u8sd_back.sv
// Back end: expands each job into its results and holds the output register.
`timescale 1ns / 1ps

module u8sd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_avail,
	input  u8sd_pkg::job_t    job,
	output logic              job_pop,
	input  logic              pop,
	output logic              empty,
	output u8sd_pkg::result_t result
);

	logic [1:0]        idx_q;
	logic              out_valid_q;
	u8sd_pkg::result_t out_q;

	logic [2:0]        total;
	logic              in_burst;
	logic              is_last;
	logic              load;
	u8sd_pkg::result_t next_res;

	// Pick the result for the current position in the job
	always_comb begin
		total    = {1'b0, job.n_bad} + ((job.tail_kind != u8sd_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
		in_burst = (idx_q < job.n_bad);
		is_last  = (({1'b0, idx_q} + 3'd1) == total);
		next_res.run_last = is_last;
		if (in_burst || job.tail_kind == u8sd_pkg::TAIL_BAD) begin
			next_res.code_point = '0;
			next_res.is_invalid = 1'b1;
		end else begin
			next_res.code_point = job.code;
			next_res.is_invalid = 1'b0;
		end
	end

	assign load    = job_avail && (!out_valid_q || pop);
	assign job_pop = load && is_last;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	// Advance the position in the job and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder.
//
//   channel   direction  handshake     payload
//   item      in         push / full   byte_in, final_byte
//   result    out        pop / empty   code_point, is_invalid, run_last
//
// A byte is taken every cycle while the job queue has room; the front end
// classifies it in the same cycle. The back end sends one result per cycle
// unless the receiver stalls, and a broken sequence gives up to four results.
// Each byte's job passes through the job queue, then its results through the
// output register. Reset clears the pending sequence, queue and output valid flag.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
	parameter int unsigned JOB_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  u8sd_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output u8sd_pkg::result_t result
);

	logic           accept;
	logic           job_push;
	u8sd_pkg::job_t wr_job;
	logic           job_full;
	logic           job_empty;
	logic           job_pop;
	u8sd_pkg::job_t rd_job;

	assign full   = job_full;
	assign accept = push && !job_full;

	u8sd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.job_push (job_push),
		.job      (wr_job)
	);

	u8sd_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (wr_job),
		.pop    (job_pop),
		.full   (job_full),
		.empty  (job_empty),
		.rd_job (rd_job)
	);

	u8sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!job_empty),
		.job       (rd_job),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

### bench/utf8_stream_decoder_tb.sv
// Self-checking testbench for the streaming UTF-8 decoder: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
	import u8sd_pkg::*;

	// Expected-result store plus a bit-level model of the decode state
	class cp_scoreboard;
		result_t        expected_q[$];
		logic [CpW-1:0] partial;
		logic [2:0]     seq_len;
		logic [1:0]     conts;
		int unsigned    errors;

		function new();
			clear_seq();
			errors = 0;
		endfunction

		function void clear_seq();
			partial = '0;
			seq_len = LenNone;
			conts   = '0;
		endfunction

		function void queue_result(logic [CpW-1:0] cp, logic bad);
			result_t r;
			r.code_point = cp;
			r.is_invalid = bad;
			r.run_last   = 1'b0;
			expected_q.push_back(r);
		endfunction

		// Decode a byte seen as the start of a new sequence
		function void open_lead(logic [7:0] b, logic fin);
			logic [2:0] len;
			if (!b[7]) begin
				queue_result({{(CpW-8){1'b0}}, b}, 1'b0);
				return;
			end
			len = LenNone;
			if (b[7:5] == 3'b110)
				len = LenTwo;
			else if (b[7:4] == 4'b1110)
				len = LenThree;
			else if (b[7:3] == 5'b11110)
				len = LenFour;
			if (len == LenNone || fin) begin
				queue_result('0, 1'b1);
				return;
			end
			partial      = '0;
			partial[7:0] = b & (8'hFF >> (int'(len) + 1));
			seq_len      = len;
			conts        = '0;
		endfunction

		// Work out the results an accepted byte causes
		function void note_byte(item_t it);
			int   first;
			int   drop;
			logic is_cont;
			logic [CpW-1:0] cp;
			first   = expected_q.size();
			is_cont = (it.byte_in[7:6] == 2'b10);
			if (seq_len == LenNone) begin
				open_lead(it.byte_in, it.final_byte);
			end else if (is_cont && int'(conts) + 2 == int'(seq_len)) begin
				cp = {partial[CpW-7:0], it.byte_in[5:0]};
				clear_seq();
				queue_result(cp, 1'b0);
			end else if (is_cont && !it.final_byte) begin
				partial = {partial[CpW-7:0], it.byte_in[5:0]};
				conts   = conts + 2'd1;
			end else begin
				// Reject the lead and buffered continuations, then retry the byte
				drop = 1 + int'(conts);
				clear_seq();
				for (int i = 0; i < drop && i < 3; i++)
					queue_result('0, 1'b1);
				open_lead(it.byte_in, it.final_byte);
			end
			if (expected_q.size() > first)
				expected_q[expected_q.size()-1].run_last = 1'b1;
		endfunction

		// Compare one popped result against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: code_point %0h is_invalid %0b run_last %0b",
					got.code_point, got.is_invalid, got.run_last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.code_point !== want.code_point) begin
				$error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
				errors++;
			end
			if (got.is_invalid !== want.is_invalid) begin
				$error("is_invalid: expected %0b, got %0b", want.is_invalid, got.is_invalid);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	localparam int unsigned NumBytes = 310;
	localparam int unsigned HoldCycles = 80;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    pop = 1'b0;
	logic    empty;
	result_t result;

	cp_scoreboard sb = new();
	item_t        byte_backlog[$];
	int unsigned  sent = 0;
	int unsigned  idle_rate = 0;
	bit           hold_req = 1'b0;

	utf8_stream_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always #1 clk = ~clk;

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		item_t it;
		it.byte_in    = b;
		it.final_byte = fin;
		byte_backlog.push_back(it);
	endtask

	task automatic idle_for(input int unsigned n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one byte and hold it until the block takes it
	task automatic send_byte(input item_t it);
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.note_byte(it);
		sent++;
	endtask

	// Drain the backlog, with random gaps between bytes
	task automatic send_backlog();
		item_t it;
		while (byte_backlog.size() != 0) begin
			it = byte_backlog.pop_front();
			if ($urandom_range(0, 7) < idle_rate)
				idle_for($urandom_range(1, 9));
			send_byte(it);
		end
	endtask

	// Push a lead byte of the given length with random payload bits
	task automatic queue_lead(input int unsigned len, input logic fin);
		logic [7:0] r;
		r = 8'($urandom());
		case (len)
			1: queue_byte({1'b0, r[6:0]}, fin);
			2: queue_byte({3'b110, r[4:0]}, fin);
			3: queue_byte({4'b1110, r[3:0]}, fin);
			default: queue_byte({5'b11110, r[2:0]}, fin);
		endcase
	endtask

	// Build one random group of bytes, mostly well-formed sequences
	task automatic queue_random_group();
		int unsigned kind;
		int unsigned len;
		int unsigned k;
		logic [7:0]  r;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			len = $urandom_range(1, 4);
			queue_lead(len, 1'b0);
			for (int i = 1; i < len; i++) begin
				r = 8'($urandom());
				queue_byte({2'b10, r[5:0]}, 1'b0);
			end
			if ($urandom_range(0, 5) == 0)
				byte_backlog[byte_backlog.size()-1].final_byte = 1'b1;
		end else if (kind < 75) begin
			// Break or truncate a multi-byte sequence partway
			len = $urandom_range(2, 4);
			k = $urandom_range(0, len - 2);
			queue_lead(len, 1'b0);
			for (int i = 0; i < k; i++) begin
				r = 8'($urandom());
				queue_byte({2'b10, r[5:0]}, 1'b0);
			end
			if ($urandom_range(0, 1) == 0)
				byte_backlog[byte_backlog.size()-1].final_byte = 1'b1;
			else
				queue_byte(8'($urandom()), $urandom_range(0, 3) == 0);
		end else if (kind < 90) begin
			queue_byte(8'($urandom()), $urandom_range(0, 7) == 0);
		end else begin
			r = 8'($urandom());
			if (r[7])
				queue_byte({2'b10, r[5:0]}, r[6]);
			else
				queue_byte({5'b11111, r[2:0]}, r[6]);
		end
	endtask

	// Receiver: random stall bursts, plus one long hold on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HoldCycles;
			end else if (stall_left == 0 && $urandom_range(0, 7) < idle_rate) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(result);
		end
	end

	// Sender: reset, directed bytes, random groups, then drain and report
	initial begin
		int unsigned next_rate;
		bit          held;
		bit          drained;
		next_rate = 40;
		held      = 1'b0;
		drained   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b1);
		// Two-byte, three-byte and four-byte sequences, up to the 21-bit maximum
		queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b0);
		queue_byte(8'hDF, 1'b0); queue_byte(8'hBF, 1'b1);
		queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF7, 1'b0); queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
		// Bad leads: a stray continuation and an all-ones byte
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		// Multi-byte lead flagged as the end of the buffer
		queue_byte(8'hC3, 1'b1);
		// Sequence broken by an ASCII byte
		queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'h41, 1'b0);
		// Truncated sequence: last continuation is flagged final
		queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b1);
		send_backlog();

		while (sent < NumBytes) begin
			if (sent >= next_rate) begin
				idle_rate = $urandom_range(0, 4);
				next_rate += 40;
			end
			// Hold the receiver off while bytes keep coming, so the queue fills
			if (!held && sent >= 100) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			// Pause until every expected result is out
			if (!drained && sent >= 200) begin
				drained = 1'b1;
				push <= 1'b0;
				do @(posedge clk); while (sb.outstanding() != 0);
			end
			if (sent >= NumBytes - 60)
				idle_rate = 0;
			queue_random_group();
			send_backlog();
		end

		push <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Timeout: generous bound over the slowest correct run
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
